// ----- rtl/dsd_pkg.sv -----
// Shared types and constants for the deck shuffle and deal core.
package dsd_pkg;

  localparam int CARD_W  = 6;
  localparam int CNT_W   = 6;
  localparam int RND_W   = 31;
  localparam int STEP_W  = $clog2(RND_W);

  typedef struct packed {
    logic              cmd;
    logic [RND_W-1:0]  random_word;
    logic [CNT_W-1:0]  deal_count;
  } in_t;

  typedef struct packed {
    logic [CARD_W-1:0] card;
    logic              card_valid;
    logic              deck_empty;
    logic              shuffle_done;
    logic              last;
  } out_t;

  // Item command codes
  localparam logic CMD_SHUFFLE = 1'b0;
  localparam logic CMD_DEAL    = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic swap_rd;
    logic swap_wr_a;
    logic swap_wr_b;
    logic deal_rd;
    logic emit_card;
    logic emit_empty;
    logic emit_shuffle;
  } dsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_deal;
    logic cnt_zero;
    logic top_zero;
    logic div_done;
    logic out_free;
  } dsd_stat_t;

endpackage

// ----- rtl/dsd_rem.sv -----
// Bit-serial restoring remainder unit: random word mod a small span.
module dsd_rem #(
  parameter int DW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dsd_pkg::RND_W-1:0]   dividend_i,
  input  logic [DW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [DW-1:0]               rem_o
);

  logic                        busy_q, done_q;
  logic [dsd_pkg::STEP_W-1:0]  step_q;
  logic [dsd_pkg::RND_W-1:0]   dvd_q;
  logic [DW-1:0]               div_q;
  logic [DW-1:0]               rem_q;
  logic [DW:0]                 rem_sh;
  logic [DW:0]                 rem_nx;

  // shift in next dividend bit, subtract span when it fits
  always_comb begin
    rem_sh = {rem_q, dvd_q[dsd_pkg::RND_W-1]};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_nx = rem_sh - {1'b0, div_q};
    end else begin
      rem_nx = rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= dsd_pkg::STEP_W'(dsd_pkg::RND_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[dsd_pkg::RND_W-2:0], 1'b0};
      rem_q <= rem_nx[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/dsd_datapath.sv -----
// Datapath: deck memory, top pointer, shuffle position, item and result registers.
module dsd_datapath #(
  parameter int DECK_SIZE = 52
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsd_pkg::in_t       in_data_i,
  input  dsd_pkg::dsd_cmd_t  cmd_i,
  output dsd_pkg::dsd_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dsd_pkg::out_t      out_data_o
);

  localparam int IW = $clog2(DECK_SIZE);
  localparam int TW = $clog2(DECK_SIZE + 1);

  // item registers
  logic                        is_deal_q;
  logic [dsd_pkg::RND_W-1:0]   rnd_q;
  logic [dsd_pkg::CNT_W-1:0]   cnt_q;

  logic [TW-1:0]               top_q;
  logic [IW-1:0]               pos_q;

  // deck memory; entries not yet written read as their own index
  logic [dsd_pkg::CARD_W-1:0]  mem_q [DECK_SIZE];
  logic [DECK_SIZE-1:0]        vld_q;
  logic [dsd_pkg::CARD_W-1:0]  rd_a_q, rd_b_q;

  logic                        out_valid_q;
  dsd_pkg::out_t               out_q;

  logic [TW-1:0]               span;
  logic [TW-1:0]               rem;
  logic                        div_done;
  logic [IW-1:0]               j_addr;
  logic [TW-1:0]               top_dec;
  logic [IW-1:0]               ra_addr;
  logic                        rd_en;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [dsd_pkg::CARD_W-1:0]  wr_data;
  logic                        out_free;

  assign span    = TW'(DECK_SIZE) - TW'(pos_q);
  assign j_addr  = pos_q + rem[IW-1:0];
  assign top_dec = top_q - TW'(1);
  assign ra_addr = cmd_i.deal_rd ? top_dec[IW-1:0] : pos_q;
  assign rd_en   = cmd_i.swap_rd | cmd_i.deal_rd;
  assign wr_en   = cmd_i.swap_wr_a | cmd_i.swap_wr_b;
  assign wr_addr = cmd_i.swap_wr_a ? pos_q : j_addr;
  assign wr_data = cmd_i.swap_wr_a ? rd_b_q : rd_a_q;
  assign out_free = !out_valid_q || out_ready_i;

  dsd_rem #(
    .DW (TW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (rnd_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_deal_q <= (in_data_i.cmd == dsd_pkg::CMD_DEAL);
      rnd_q     <= in_data_i.random_word;
      cnt_q     <= in_data_i.deal_count;
    end else if (cmd_i.deal_rd) begin
      cnt_q     <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TW'(DECK_SIZE);
      pos_q <= '0;
    end else begin
      if (cmd_i.start_div && pos_q == '0) begin
        top_q <= TW'(DECK_SIZE);
      end else if (cmd_i.deal_rd) begin
        top_q <= top_dec;
      end
      if (cmd_i.emit_shuffle) begin
        pos_q <= (pos_q == IW'(DECK_SIZE - 1)) ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= vld_q[ra_addr] ? mem_q[ra_addr] : dsd_pkg::CARD_W'(ra_addr);
      rd_b_q <= vld_q[j_addr]  ? mem_q[j_addr]  : dsd_pkg::CARD_W'(j_addr);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_card || cmd_i.emit_empty || cmd_i.emit_shuffle) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_card) begin
      out_q.card         <= rd_a_q;
      out_q.card_valid   <= 1'b1;
      out_q.deck_empty   <= 1'b0;
      out_q.shuffle_done <= 1'b0;
      out_q.last         <= (cnt_q == '0);
    end else if (cmd_i.emit_empty) begin
      out_q.card         <= '0;
      out_q.card_valid   <= 1'b0;
      out_q.deck_empty   <= 1'b1;
      out_q.shuffle_done <= 1'b0;
      out_q.last         <= 1'b1;
    end else if (cmd_i.emit_shuffle) begin
      out_q.card         <= '0;
      out_q.card_valid   <= 1'b0;
      out_q.deck_empty   <= 1'b0;
      out_q.shuffle_done <= (pos_q == IW'(DECK_SIZE - 1));
      out_q.last         <= 1'b1;
    end
  end

  assign stat_o.is_deal  = is_deal_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.top_zero = (top_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/dsd_ctrl.sv -----
// Controller state machine sequencing shuffle steps and deals.
module dsd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dsd_pkg::dsd_stat_t stat_i,
  output dsd_pkg::dsd_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SWA   = 4'd4;
  localparam logic [3:0] S_SWB   = 4'd5;
  localparam logic [3:0] S_SEMIT = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_DEMIT = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat_i.is_deal) begin
          cmd_o.start_div = 1'b1;
          state_d         = S_DIV;
        end else if (stat_i.cnt_zero) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_DCHK;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        cmd_o.swap_rd = 1'b1;
        state_d       = S_SWA;
      end
      S_SWA: begin
        cmd_o.swap_wr_a = 1'b1;
        state_d         = S_SWB;
      end
      S_SWB: begin
        cmd_o.swap_wr_b = 1'b1;
        state_d         = S_SEMIT;
      end
      S_SEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_shuffle = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_DCHK: begin
        if (stat_i.top_zero) begin
          if (stat_i.out_free) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.deal_rd = 1'b1;
          state_d       = S_DEMIT;
        end
      end
      S_DEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_card = 1'b1;
          state_d         = stat_i.cnt_zero ? S_IDLE : S_DCHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/deck_shuffle_and_deal_core.sv -----
// Top level of the deck shuffle and deal core.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat is one item.
//   cmd = shuffle: one Fisher-Yates step at the current shuffle position,
//   swapping entry pos with pos + (random_word mod (DECK_SIZE - pos)).
//   A step at position 0 first refills the deck top to full.
//   cmd = deal: pops up to deal_count cards from the top, one result beat
//   each; if the deck runs dry one deck_empty beat ends the deal.
// Output channel (out_valid_o / out_ready_i / out_data_o): result beats,
//   last set on the final beat of each item; a zero-count deal has none.
// Throughput: one item at a time. A shuffle step is paced by the bit-serial
//   remainder unit (one dividend bit per cycle, 31 bits) and the swap on the
//   single write port of the deck memory. A deal does a memory read, then
//   an emit, for each card.
// The result register lets a new item be accepted while a beat waits.
// Stall: a held result beat freezes the controller at its next emit.
// Reset: deck in identity order via per-entry valid bits (no clearing
//   pass), top = DECK_SIZE, shuffle position 0, output channel empty.
module deck_shuffle_and_deal_core #(
  parameter int DECK_SIZE = 52
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsd_pkg::out_t out_data_o
);

  dsd_pkg::dsd_cmd_t  cmd;
  dsd_pkg::dsd_stat_t stat;

  // sequencer: one state per memory access or emit slot
  dsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // deck memory, pointers, remainder unit and result register
  dsd_datapath #(
    .DECK_SIZE (DECK_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/dsd_checker.sv -----
// Port-level assertions for the deck shuffle and deal core, with bind.
module dsd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dsd_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_card_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.card_valid |->
      !out_data_o.deck_empty && !out_data_o.shuffle_done)
    else $error("card beat carries empty or shuffle flag");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.card_valid |-> out_data_o.last)
    else $error("non-card beat without last");

  a_no_card_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.card_valid |-> out_data_o.card == '0)
    else $error("non-card beat with nonzero card code");

endmodule

bind deck_shuffle_and_deal_core dsd_checker u_dsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
